### rtl/clt_pkg.sv
`timescale 1ns / 1ps

package clt_pkg;

  // Line and argument limits
  localparam int LINE_LENGTH = 128;
  localparam int WORD_LIMIT  = 8;

  localparam int WCW = $clog2(WORD_LIMIT + 1);

  // Most results one input byte can cause
  localparam int MAX_RES = 3;

  // Result queue depth
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0] ESCAPE_RESET = 8'd92;
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_QUOTE = 8'd34;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_NUL    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_TOO_MANY   = 3'd2,
    ST_TRAIL_ESC  = 3'd3,
    ST_OPEN_QUOTE = 3'd4
  } status_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [6:0] position;
    logic       starts_word;
    logic [2:0] word_index;
    status_t    line_status;
    logic [3:0] word_total;
    logic       last;
  } res_t;

  // Results of one input transaction, handed to the queue
  typedef struct packed {
    logic [1:0]             count;
    res_t [MAX_RES-1:0]     res;
  } push_t;

endpackage

### rtl/clt_core.sv
`timescale 1ns / 1ps

module clt_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     in_byte,
  input  logic [7:0]     escape_code,
  output clt_pkg::push_t push
);
  import clt_pkg::*;

  typedef struct packed {
    logic           escape_pending;
    logic           inside_word;
    logic           inside_quote;
    logic [WCW-1:0] word_count;
    logic [7:0]     write_position;
    logic [7:0]     bytes_consumed;
    logic           start_mark_pending;
    logic           discarding;
  } state_t;

  state_t st;
  state_t st_next;

  logic   term;
  logic   do_open;
  logic   do_put;
  kind_t  put_kind;
  logic   abort;
  logic [1:0] n;
  res_t [MAX_RES-1:0] res;

  function automatic res_t item_res(kind_t kind, logic [7:0] b, state_t s);
    res_t r;
    r             = '0;
    r.kind        = kind;
    r.data        = (kind == KIND_BYTE) ? b : 8'd0;
    r.position    = s.write_position[6:0];
    r.starts_word = s.start_mark_pending;
    r.word_index  = (s.word_count != '0) ? 3'(s.word_count - 1'b1) : 3'd0;
    return r;
  endfunction

  function automatic res_t status_res(status_t code, logic [WCW-1:0] wc);
    res_t r;
    r             = '0;
    r.kind        = KIND_STATUS;
    r.line_status = code;
    r.word_total  = 4'(wc);
    r.last        = 1'b1;
    return r;
  endfunction

  function automatic state_t cleared(state_t s);
    state_t c;
    c            = '0;
    c.discarding = s.discarding;
    return c;
  endfunction

  // Classify the byte against the current line state
  always_comb begin
    term     = (in_byte == CH_NUL) || (in_byte == CH_LF) || (in_byte == CH_CR);
    do_open  = 1'b0;
    do_put   = 1'b0;
    put_kind = KIND_BYTE;
    if (st.escape_pending) begin
      do_open = 1'b1;
      do_put  = 1'b1;
    end else if (in_byte == escape_code) begin
      do_open = 1'b1;
    end else if (in_byte == CH_SPACE) begin
      if (st.inside_quote) begin
        do_open = 1'b1;
        do_put  = 1'b1;
      end else if (st.inside_word) begin
        do_put   = 1'b1;
        put_kind = KIND_NUL;
      end
    end else begin
      do_open = 1'b1;
      do_put  = (in_byte != CH_QUOTE);
    end
  end

  // Work out the next state and up to three results
  always_comb begin
    st_next = st;
    n       = 2'd0;
    res     = '0;
    abort   = 1'b0;
    if (st.discarding) begin
      if (term) begin
        st_next.discarding = 1'b0;
      end
    end else begin
      if (!term) begin
        st_next.bytes_consumed = st.bytes_consumed + 8'd1;
        // Open an argument, or give up on the line at the limit
        if (do_open && !st.inside_word) begin
          if (st.word_count >= WCW'(WORD_LIMIT)) begin
            res[n] = status_res(ST_TOO_MANY, st.word_count);
            n      = n + 2'd1;
            st_next            = cleared(st_next);
            st_next.discarding = 1'b1;
            abort              = 1'b1;
          end else begin
            st_next.word_count         = st.word_count + 1'b1;
            st_next.inside_word        = 1'b1;
            st_next.start_mark_pending = 1'b1;
          end
        end
        if (!abort) begin
          if (do_put) begin
            res[n] = item_res(put_kind, in_byte, st_next);
            n      = n + 2'd1;
            st_next.start_mark_pending = 1'b0;
            st_next.write_position     = st_next.write_position + 8'd1;
          end
          if (st.escape_pending) begin
            st_next.escape_pending = 1'b0;
          end else if (in_byte == escape_code) begin
            st_next.escape_pending = 1'b1;
          end else if (in_byte == CH_SPACE) begin
            if (!st.inside_quote) begin
              st_next.inside_word = 1'b0;
            end
          end else if (in_byte == CH_QUOTE) begin
            st_next.inside_quote = !st.inside_quote;
          end
        end
      end
      // Close the line on a terminator or at the length limit
      if (term || (!abort && (st_next.bytes_consumed >= 8'(LINE_LENGTH)))) begin
        if (st_next.escape_pending) begin
          res[n] = status_res(ST_TRAIL_ESC, st_next.word_count);
          n      = n + 2'd1;
        end else begin
          if (st_next.inside_word) begin
            res[n] = item_res(KIND_NUL, 8'd0, st_next);
            n      = n + 2'd1;
          end
          if (st_next.inside_quote) begin
            res[n] = status_res(ST_OPEN_QUOTE, st_next.word_count);
          end else if (st_next.word_count == '0) begin
            res[n] = status_res(ST_EMPTY, st_next.word_count);
          end else begin
            res[n] = status_res(ST_OK, st_next.word_count);
          end
          n = n + 2'd1;
        end
        st_next = cleared(st_next);
        if (!term) begin
          st_next.discarding = 1'b1;
        end
      end
    end
  end

  // Hand the results to the queue
  always_comb begin
    push.count = accept ? n : 2'd0;
    push.res   = res;
  end

  // Advance the line state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

endmodule

### rtl/clt_queue.sv
`timescale 1ns / 1ps

module clt_queue (
  input  logic           clk,
  input  logic           rst,
  input  clt_pkg::push_t push,
  input  logic           pop,
  output logic           not_empty,
  output logic           has_room,
  output clt_pkg::res_t  head
);
  import clt_pkg::*;

  res_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign not_empty = (count != '0);
  assign has_room  = (count <= (QAW+1)'(QDEPTH - MAX_RES));
  assign head      = mem[rd_ptr];

  // Write up to three results at consecutive slots
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (k < int'(push.count)) begin
        mem[wr_ptr + QAW'(k)] <= push.res[k];
      end
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QAW'(push.count);
      rd_ptr <= rd_ptr + QAW'(pop);
      count  <= count + (QAW+1)'(push.count) - (QAW+1)'(pop);
    end
  end

endmodule

### rtl/command_line_tokenizer.sv
`timescale 1ns / 1ps

// Command-line tokenizer: takes one line byte per transaction and returns the
// compacted argument bytes, word-end NULs and one line status per line. Results
// leave a four-entry result queue at one per cycle while out_stall is low. The
// input is taken while that queue holds at most one result, so a stream of plain
// bytes runs at one byte per cycle while the output does not stall; a byte that
// ends a line can cause up to three results, and the input then stalls while the
// queue drains. escape_code changes take effect from the next byte.
module command_line_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [6:0] out_position,
  output logic       starts_word,
  output logic [2:0] word_index,
  output logic [2:0] line_status,
  output logic [3:0] word_total,
  output logic       last
);
  import clt_pkg::*;

  logic [7:0] escape_code;
  logic       accept;
  logic       pop;
  logic       has_room;
  push_t      push;
  res_t       head;

  // Hold the escape register
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_code <= ESCAPE_RESET;
    end else if (cfg_write) begin
      escape_code <= cfg_data;
    end
  end

  assign in_stall = !has_room;
  assign accept   = in_valid && has_room;
  assign pop      = out_valid && !out_stall;

  clt_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_byte     (in_byte),
    .escape_code (escape_code),
    .push        (push)
  );

  clt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .not_empty (out_valid),
    .has_room  (has_room),
    .head      (head)
  );

  // Drive the result transaction fields
  assign out_kind     = head.kind;
  assign out_byte     = head.data;
  assign out_position = head.position;
  assign starts_word  = head.starts_word;
  assign word_index   = head.word_index;
  assign line_status  = head.line_status;
  assign word_total   = head.word_total;
  assign last         = head.last;

endmodule

### sim/command_line_tokenizer_tb.sv
`timescale 1ns / 1ps

module command_line_tokenizer_tb;
  import clt_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int NUM_PHASES   = 7;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 10;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [6:0] out_position;
  logic       starts_word;
  logic [2:0] word_index;
  logic [2:0] line_status;
  logic [3:0] word_total;
  logic       last;

  command_line_tokenizer u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .out_position (out_position),
    .starts_word  (starts_word),
    .word_index   (word_index),
    .line_status  (line_status),
    .word_total   (word_total),
    .last         (last)
  );

  always #4 clk = ~clk;

  // Tokenizer state mirrored on the bench side
  logic [7:0] esc_code = ESCAPE_RESET;
  bit         esc_pend, in_word, quoted, mark_pend, skipping;
  int         nwords;
  logic [7:0] wr_pos, consumed;

  res_t pending_tokens[$];
  int   mismatches = 0;
  int   in_idle_pct, out_idle_pct;
  bit   hold_req = 0;
  int   hold_left = 0;
  int   idle_cycles = 0;
  int   random_sent = 0;
  logic [7:0] line_buf[$];

  function automatic void put_entry(kind_t k, logic [7:0] b);
    res_t r;
    r = '0;
    r.kind        = k;
    r.data        = b;
    r.position    = wr_pos[6:0];
    r.starts_word = mark_pend;
    r.word_index  = (nwords != 0) ? 3'(nwords - 1) : 3'd0;
    pending_tokens.push_back(r);
    mark_pend = 0;
    wr_pos    = wr_pos + 8'd1;
  endfunction

  function automatic void put_status(status_t s);
    res_t r;
    r = '0;
    r.kind        = KIND_STATUS;
    r.line_status = s;
    r.word_total  = 4'(nwords);
    r.last        = 1'b1;
    pending_tokens.push_back(r);
  endfunction

  function automatic void clear_line();
    esc_pend  = 0;
    in_word   = 0;
    quoted    = 0;
    nwords    = 0;
    wr_pos    = 8'd0;
    consumed  = 8'd0;
    mark_pend = 0;
  endfunction

  // Open an argument; drop the rest of the line past the word limit
  function automatic bit open_arg();
    if (in_word) return 1'b1;
    if (nwords >= WORD_LIMIT) begin
      put_status(ST_TOO_MANY);
      clear_line();
      skipping = 1;
      return 1'b0;
    end
    nwords++;
    in_word   = 1;
    mark_pend = 1;
    return 1'b1;
  endfunction

  function automatic void end_line();
    if (esc_pend) begin
      put_status(ST_TRAIL_ESC);
    end else begin
      if (in_word) put_entry(KIND_NUL, 8'd0);
      if (quoted) put_status(ST_OPEN_QUOTE);
      else if (nwords == 0) put_status(ST_EMPTY);
      else put_status(ST_OK);
    end
    clear_line();
  endfunction

  function automatic bit is_term(logic [7:0] b);
    return (b == CH_NUL) || (b == CH_LF) || (b == CH_CR);
  endfunction

  function automatic void tokenize_byte(logic [7:0] b);
    if (skipping) begin
      if (is_term(b)) skipping = 0;
      return;
    end
    if (is_term(b)) begin
      end_line();
      return;
    end
    consumed = consumed + 8'd1;
    if (esc_pend) begin
      if (!open_arg()) return;
      put_entry(KIND_BYTE, b);
      esc_pend = 0;
    end else if (b == esc_code) begin
      if (!open_arg()) return;
      esc_pend = 1;
    end else if (b == CH_SPACE) begin
      if (quoted) begin
        if (!open_arg()) return;
        put_entry(KIND_BYTE, b);
      end else if (in_word) begin
        put_entry(KIND_NUL, 8'd0);
        in_word = 0;
      end
    end else if (b == CH_QUOTE) begin
      if (!open_arg()) return;
      quoted = !quoted;
    end else begin
      if (!open_arg()) return;
      put_entry(KIND_BYTE, b);
    end
    // Overlong line ends here, the rest is dropped
    if (consumed >= LINE_LENGTH) begin
      end_line();
      skipping = 1;
    end
  endfunction

  // Offer one byte; keep valid and payload steady until taken
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    do @(posedge clk); while (in_stall);
    tokenize_byte(b);
  endtask

  // Stop offering and wait until every predicted token has left the block
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_escape(input logic [7:0] v);
    drain();
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_data  = v;
    @(negedge clk);
    cfg_write = 1'b0;
    esc_code  = v;
  endtask

  function automatic logic [7:0] any_nonterm();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (is_term(v));
    return v;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] v;
    do v = 8'($urandom_range(33, 126));
    while (v == CH_QUOTE || v == esc_code || is_term(v));
    return v;
  endfunction

  function automatic logic [7:0] pick_term();
    case ($urandom_range(2))
      0:       return CH_NUL;
      1:       return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic void add_word();
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(9))
        0: begin
          line_buf.push_back(esc_code);
          line_buf.push_back(8'($urandom_range(0, 255)));
        end
        1: begin
          line_buf.push_back(CH_QUOTE);
          repeat ($urandom_range(0, 3))
            line_buf.push_back($urandom_range(1) ? CH_SPACE : plain_char());
          line_buf.push_back(CH_QUOTE);
        end
        2:       line_buf.push_back(any_nonterm());
        default: line_buf.push_back(plain_char());
      endcase
    end
  endfunction

  // Build one line: mostly well-formed, some broken, some noise
  function automatic void make_line(bit overlong);
    int style, nw;
    line_buf.delete();
    style = $urandom_range(99);
    if (overlong || style == 0) begin
      repeat ($urandom_range(LINE_LENGTH - 2, LINE_LENGTH + 10))
        line_buf.push_back(any_nonterm());
    end else if (style < 10) begin
      repeat ($urandom_range(1, 10)) line_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      nw = ($urandom_range(9) == 0) ? $urandom_range(WORD_LIMIT + 1, WORD_LIMIT + 3)
                                    : $urandom_range(0, WORD_LIMIT);
      repeat ($urandom_range(0, 2)) line_buf.push_back(CH_SPACE);
      for (int k = 0; k < nw; k++) begin
        add_word();
        repeat ($urandom_range(1, 2)) line_buf.push_back(CH_SPACE);
      end
      if (style < 16) begin
        line_buf.push_back(esc_code);
      end else if (style < 22) begin
        line_buf.push_back(CH_QUOTE);
        line_buf.push_back(plain_char());
      end
    end
    if ($urandom_range(19) != 0) line_buf.push_back(pick_term());
  endfunction

  // Receiver: random stall, or one long hold-off when asked
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < out_idle_pct);
    end
  end

  function automatic void flag_mismatch(string what, res_t want, res_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display({"%s: expected kind %0d byte %0d pos %0d start %0d idx %0d st %0d ",
                "tot %0d last %0d, got kind %0d byte %0d pos %0d start %0d ",
                "idx %0d st %0d tot %0d last %0d"},
               what, want.kind, want.data, want.position, want.starts_word,
               want.word_index, want.line_status, want.word_total, want.last,
               got.kind, got.data, got.position, got.starts_word,
               got.word_index, got.line_status, got.word_total, got.last);
  endfunction

  // Compare each result transaction with the oldest predicted token
  always @(posedge clk) begin
    res_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got.kind        = kind_t'(out_kind);
      got.data        = out_byte;
      got.position    = out_position;
      got.starts_word = starts_word;
      got.word_index  = word_index;
      got.line_status = status_t'(line_status);
      got.word_total  = word_total;
      got.last        = last;
      if (pending_tokens.size() == 0) begin
        flag_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_tokens.pop_front();
        if (got.kind !== want.kind || got.data !== want.data ||
            got.position !== want.position || got.starts_word !== want.starts_word ||
            got.word_index !== want.word_index || got.line_status !== want.line_status ||
            got.word_total !== want.word_total || got.last !== want.last)
          flag_mismatch("result mismatch", want, got);
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  typedef struct {
    logic [7:0] b;
    bit         typed;
    status_t    st;
  } row_t;

  // Directed lines; a status is typed in where it is plain from the bytes
  row_t rows[25] = '{
    '{8'h0D,        1, ST_EMPTY},      // empty line right after reset
    '{CH_QUOTE,     0, ST_OK},         // "" opens an empty argument
    '{CH_QUOTE,     0, ST_OK},
    '{CH_SPACE,     0, ST_OK},
    '{8'hFF,        0, ST_OK},
    '{8'h01,        0, ST_OK},
    '{CH_LF,        1, ST_OK},
    '{ESCAPE_RESET, 0, ST_OK},         // escaped space, quote, escape
    '{CH_SPACE,     0, ST_OK},
    '{ESCAPE_RESET, 0, ST_OK},
    '{CH_QUOTE,     0, ST_OK},
    '{ESCAPE_RESET, 0, ST_OK},
    '{ESCAPE_RESET, 0, ST_OK},
    '{CH_NUL,       1, ST_OK},
    '{8'h61,        0, ST_OK},         // escape right before the terminator
    '{ESCAPE_RESET, 0, ST_OK},
    '{CH_CR,        1, ST_TRAIL_ESC},
    '{CH_QUOTE,     0, ST_OK},         // quote left open
    '{8'h71,        0, ST_OK},
    '{CH_SPACE,     0, ST_OK},
    '{8'h7F,        0, ST_OK},
    '{CH_NUL,       1, ST_OPEN_QUOTE},
    '{8'h80,        0, ST_OK},
    '{CH_SPACE,     0, ST_OK},
    '{CH_LF,        1, ST_OK}
  };

  logic [7:0] phase_escape[NUM_PHASES] = '{ESCAPE_RESET, 8'hFF, 8'h00, CH_SPACE,
                                           CH_QUOTE, CH_CR, ESCAPE_RESET};

  initial begin
    res_t tail;
    clear_line();
    skipping     = 0;
    in_idle_pct  = 8;
    out_idle_pct = 70;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows
    foreach (rows[i]) begin
      send_byte(rows[i].b);
      if (rows[i].typed) begin
        tail = pending_tokens.pop_back();
        tail.line_status = rows[i].st;
        pending_tokens.push_back(tail);
      end
    end

    // Random lines, one escape setting per phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 2) begin
        in_idle_pct  = 70;
        out_idle_pct = 8;
      end else if (ph == 4) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      if (ph != 0) write_escape(phase_escape[ph]);
      if (ph == 1) hold_req = 1;
      while (random_sent < (ph + 1) * RANDOM_ITEMS / NUM_PHASES) begin
        make_line(ph == 0 && random_sent == 0);
        foreach (line_buf[j]) begin
          send_byte(line_buf[j]);
          random_sent++;
        end
      end
    end

    // Let the last results out
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_tokens.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### sim.f
rtl/clt_pkg.sv
rtl/clt_core.sv
rtl/clt_queue.sv
rtl/command_line_tokenizer.sv
sim/command_line_tokenizer_tb.sv
